@@ design/assert_macros.svh @@
// Assertion macros for the RTL of the trajectory evaluator.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Condition in one cycle implies an expression in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ design/mjt_pkg.sv @@
// Package of the minimum-jerk trajectory evaluator: widths, codes and payload types.
// Depends on nothing; used by mjt_mul, min_jerk_trajectory_point and the testbench.
`default_nettype none

package mjt_pkg;

   // Field widths of the request and response.
   localparam int TIME_W = 32;
   localparam int AMP_W  = 32;

   // Normalized time is an unsigned Q0.32 fraction.
   localparam int FRAC_W = 32;

   // Limb width of the pipelined multipliers and their register depth.
   localparam int LIMB_W     = 32;
   localparam int MUL_STAGES = 3;

   // Quintic coefficients: 10 s^3 - 15 s^4 + 6 s^5.
   localparam logic [3:0] POLY_C3 = 4'd10;
   localparam logic [3:0] POLY_C4 = 4'd15;
   localparam logic [3:0] POLY_C5 = 4'd6;

   // Inner factor 10 - 15 s + 6 s^2 scaled by 2^64 needs four integer bits.
   localparam int QV_W = 2 * FRAC_W + 4;
   localparam logic [QV_W-1:0] QV_BASE = QV_W'(POLY_C3) << (2 * FRAC_W);

   // The full polynomial carries 5 * FRAC_W fraction bits.
   localparam int POLY_FRAC_W = 5 * FRAC_W;

   // Register port.
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_LSB = 2;
   localparam logic [TIME_W-1:0] END_TICK_RESET = 32'd800;

   typedef enum logic {
      CSR_START_TICK = 1'b0,
      CSR_END_TICK   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_BEFORE = 2'd0,
      PHASE_MOVING = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   typedef struct packed {
      logic        [TIME_W-1:0] time_tick;
      logic signed [AMP_W-1:0]  amplitude;
   } req_type;

   typedef struct packed {
      logic signed [AMP_W-1:0] position;
      phase_type               phase;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/mjt_div.sv @@
// Pipelined restoring divider that forms the fraction floor(num * 2^Q_W / den).
// One quotient bit per register stage; standalone, no package needed.
`default_nettype none

module mjt_div #(
   parameter int NUM_W = 32,
   parameter int Q_W   = 32
) (
   input  logic             clock,
   input  logic [Q_W-1:0]   stage_en,
   input  logic [NUM_W-1:0] num,
   input  logic [NUM_W-1:0] den,
   output logic [Q_W-1:0]   quot
);

   // Partial remainder and divisor travel with the quotient bits.
   logic [NUM_W-1:0] rem_ff  [Q_W-1];
   logic [NUM_W-1:0] den_ff  [Q_W-1];
   logic [Q_W-1:0]   quot_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [NUM_W-1:0] rem_prev;
      logic [NUM_W-1:0] den_prev;
      logic [Q_W-1:0]   quot_prev;
      logic [NUM_W:0]   rem_dbl;
      logic [NUM_W:0]   rem_sub;
      logic             take;

      if (k == 0) begin : g_first
         assign rem_prev  = num;
         assign den_prev  = den;
         assign quot_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign quot_prev = quot_ff[k-1];
      end

      // Shift the remainder left and subtract the divisor when it fits.
      assign rem_dbl = {rem_prev, 1'b0};
      assign rem_sub = rem_dbl - {1'b0, den_prev};
      assign take    = (rem_dbl >= {1'b0, den_prev});

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            quot_ff[k] <= {quot_prev[Q_W-2:0], take};
         end
      end

      // The last stage only needs its quotient.
      if (k < Q_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               rem_ff[k] <= take ? rem_sub[NUM_W-1:0] : rem_dbl[NUM_W-1:0];
               den_ff[k] <= den_prev;
            end
         end
      end
   end

   assign quot = quot_ff[Q_W-1];

endmodule

`default_nettype wire

@@ design/mjt_mul.sv @@
// Pipelined unsigned multiplier built from 32x32 limb products in three stages.
// Depends on mjt_pkg for the limb width and stage count.
`default_nettype none

module mjt_mul
   import mjt_pkg::*;
#(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  logic                  clock,
   input  logic [MUL_STAGES-1:0] stage_en,
   input  logic [A_W-1:0]        a,
   input  logic [B_W-1:0]        b,
   output logic [A_W+B_W-1:0]    prod
);

   localparam int NA    = (A_W + LIMB_W - 1) / LIMB_W;
   localparam int NB    = (B_W + LIMB_W - 1) / LIMB_W;
   localparam int ROW_W = (NA + 1) * LIMB_W;
   localparam int SUM_W = (NA + NB) * LIMB_W;

   logic [NA*LIMB_W-1:0] a_ext;
   logic [NB*LIMB_W-1:0] b_ext;
   logic [2*LIMB_W-1:0]  pp_ff     [NA][NB];
   logic [ROW_W-1:0]     even_row  [NB];
   logic [ROW_W-1:0]     odd_row   [NB];
   logic [ROW_W-1:0]     row_ff    [NB];
   logic [SUM_W-1:0]     sum_in;
   logic [SUM_W-1:0]     sum_ff;

   assign a_ext = (NA*LIMB_W)'(a);
   assign b_ext = (NB*LIMB_W)'(b);

   // Stage one: every limb product in its own multiplier.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= (2*LIMB_W)'(a_ext[i*LIMB_W +: LIMB_W])
                            * (2*LIMB_W)'(b_ext[j*LIMB_W +: LIMB_W]);
            end
         end
      end
   end

   // Products of even and of odd limbs do not overlap, so each set is a
   // plain concatenation and one row needs a single add.
   always_comb begin
      for (int j = 0; j < NB; j++) begin
         even_row[j] = '0;
         odd_row[j]  = '0;
         for (int i = 0; i < NA; i++) begin
            if ((i & 1) == 0) begin
               even_row[j][i*LIMB_W +: 2*LIMB_W] = pp_ff[i][j];
            end else begin
               odd_row[j][i*LIMB_W +: 2*LIMB_W] = pp_ff[i][j];
            end
         end
      end
   end

   // Stage two: one row per limb of b.
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int j = 0; j < NB; j++) begin
            row_ff[j] <= even_row[j] + odd_row[j];
         end
      end
   end

   // Stage three: shifted rows summed into the full product.
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < NB; j++) begin
         sum_in = sum_in + (SUM_W'(row_ff[j]) << (j * LIMB_W));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         sum_ff <= sum_in;
      end
   end

   assign prod = sum_ff[A_W+B_W-1:0];

endmodule

`default_nettype wire

@@ design/min_jerk_trajectory_point.sv @@
// Minimum-jerk (quintic) trajectory evaluator; uses mjt_pkg, mjt_div and mjt_mul.
// Throughput: one request per cycle, set by a 46-stage pipeline in which a
// stage stalls only when it is full and the stage after it cannot take data.
// Reset clears every stage's valid bit and sets start_tick to 0 and end_tick to 800.
`default_nettype none
`include "assert_macros.svh"

module min_jerk_trajectory_point
   import mjt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Stage map: entry, divider, s^2, s^3 with inner factor, polynomial,
   // amplitude product, output register.
   localparam int DIV_FIRST  = 1;
   localparam int DIV_LAST   = DIV_FIRST + FRAC_W - 1;
   localparam int SQ2_FIRST  = DIV_LAST + 1;
   localparam int SQ2_LAST   = SQ2_FIRST + MUL_STAGES - 1;
   localparam int SQ3_FIRST  = SQ2_LAST + 1;
   localparam int SQ3_LAST   = SQ3_FIRST + MUL_STAGES - 1;
   localparam int POLY_FIRST = SQ3_LAST + 1;
   localparam int POLY_LAST  = POLY_FIRST + MUL_STAGES - 1;
   localparam int PROD_FIRST = POLY_LAST + 1;
   localparam int PROD_LAST  = PROD_FIRST + MUL_STAGES - 1;
   localparam int OUT_STAGE  = PROD_LAST + 1;
   localparam int NUM_STAGES = OUT_STAGE + 1;

   typedef struct packed {
      logic [AMP_W-1:0] amp;
      logic [AMP_W-1:0] mag;
      phase_type        phase;
   } side_type;

   // Configuration registers.
   logic [TIME_W-1:0] start_tick_ff;
   logic [TIME_W-1:0] end_tick_ff;
   logic              csr_write;
   csr_index_type     csr_index;

   // Pipeline control.
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   stage_adv;

   // Entry stage.
   logic              time_before;
   logic              time_done;
   phase_type         entry_phase;
   logic [AMP_W-1:0]  entry_mag;
   logic [TIME_W-1:0] num_ff;
   logic [TIME_W-1:0] den_ff;
   side_type          side_ff [PROD_LAST+1];

   // Arithmetic path.
   logic [FRAC_W-1:0]           sq;
   logic [FRAC_W-1:0]           sq_ff [MUL_STAGES];
   logic [2*FRAC_W-1:0]         sq2;
   logic [3*FRAC_W-1:0]         sq3;
   logic [QV_W-1:0]             qv_in;
   logic [QV_W-1:0]             qv_ff [MUL_STAGES];
   logic [3*FRAC_W+QV_W-1:0]    poly;
   logic [POLY_FRAC_W+AMP_W-1:0] scaled;
   logic [AMP_W-1:0]            scaled_hi;
   logic                        scaled_frac;
   logic                        amp_neg;
   logic [AMP_W-1:0]            curve;
   rsp_type                     out_in;
   rsp_type                     out_ff;

   // Register port: writes on the access cycle, reads return the register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_INDEX_LSB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_tick_ff <= '0;
         end_tick_ff   <= END_TICK_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_START_TICK: start_tick_ff <= csr_pwdata[TIME_W-1:0];
            CSR_END_TICK:   end_tick_ff   <= csr_pwdata[TIME_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_START_TICK: csr_prdata = CSR_DATA_W'(start_tick_ff);
         CSR_END_TICK:   csr_prdata = CSR_DATA_W'(end_tick_ff);
      endcase
   end

   // A stage advances when it is empty or the stage after it advances.
   assign stage_adv[NUM_STAGES] = rsp_ready;
   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_adv
      assign stage_adv[g] = !valid_ff[g] || stage_adv[g+1];
   end

   assign req_ready = stage_adv[0];

   always_comb begin
      valid_in = valid_ff;
      if (stage_adv[0]) begin
         valid_in[0] = req_valid;
      end
      for (int g = 1; g < NUM_STAGES; g++) begin
         if (stage_adv[g]) begin
            valid_in[g] = valid_ff[g-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Entry: classify the request and set up the time fraction.
   assign time_before = req_data.time_tick < start_tick_ff;
   assign time_done   = (end_tick_ff <= start_tick_ff) || (req_data.time_tick >= end_tick_ff);
   assign entry_phase = time_before ? PHASE_BEFORE : (time_done ? PHASE_DONE : PHASE_MOVING);
   assign entry_mag   = req_data.amplitude[AMP_W-1] ? (AMP_W'(0) - req_data.amplitude)
                                                   : req_data.amplitude;

   always_ff @(posedge clock) begin
      if (stage_adv[0]) begin
         num_ff     <= req_data.time_tick - start_tick_ff;
         den_ff     <= end_tick_ff - start_tick_ff;
         side_ff[0] <= '{amp: req_data.amplitude, mag: entry_mag, phase: entry_phase};
      end
   end

   // Amplitude, magnitude and phase follow the request down the pipeline.
   for (genvar g = 1; g <= PROD_LAST; g++) begin : g_side
      always_ff @(posedge clock) begin
         if (stage_adv[g]) begin
            side_ff[g] <= side_ff[g-1];
         end
      end
   end

   // s = (t - start) / (end - start) as Q0.32.
   mjt_div #(
      .NUM_W (TIME_W),
      .Q_W   (FRAC_W)
   ) u_div (
      .clock    (clock),
      .stage_en (stage_adv[DIV_LAST:DIV_FIRST]),
      .num      (num_ff),
      .den      (den_ff),
      .quot     (sq)
   );

   // s^2, with s delayed alongside for the next product.
   mjt_mul #(
      .A_W (FRAC_W),
      .B_W (FRAC_W)
   ) u_mul_sq2 (
      .clock    (clock),
      .stage_en (stage_adv[SQ2_LAST:SQ2_FIRST]),
      .a        (sq),
      .b        (sq),
      .prod     (sq2)
   );

   for (genvar k = 0; k < MUL_STAGES; k++) begin : g_sq_dly
      always_ff @(posedge clock) begin
         if (stage_adv[SQ2_FIRST+k]) begin
            sq_ff[k] <= (k == 0) ? sq : sq_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // s^3, and in parallel the inner factor 10 - 15 s + 6 s^2 scaled by 2^64.
   mjt_mul #(
      .A_W (2*FRAC_W),
      .B_W (FRAC_W)
   ) u_mul_sq3 (
      .clock    (clock),
      .stage_en (stage_adv[SQ3_LAST:SQ3_FIRST]),
      .a        (sq2),
      .b        (sq_ff[MUL_STAGES-1]),
      .prod     (sq3)
   );

   assign qv_in = QV_BASE + (QV_W'(sq2) * QV_W'(POLY_C5))
                - ((QV_W'(sq_ff[MUL_STAGES-1]) * QV_W'(POLY_C4)) << FRAC_W);

   for (genvar k = 0; k < MUL_STAGES; k++) begin : g_qv_dly
      always_ff @(posedge clock) begin
         if (stage_adv[SQ3_FIRST+k]) begin
            qv_ff[k] <= (k == 0) ? qv_in : qv_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // Polynomial value with 160 fraction bits; it stays below one.
   mjt_mul #(
      .A_W (3*FRAC_W),
      .B_W (QV_W)
   ) u_mul_poly (
      .clock    (clock),
      .stage_en (stage_adv[POLY_LAST:POLY_FIRST]),
      .a        (sq3),
      .b        (qv_ff[MUL_STAGES-1]),
      .prod     (poly)
   );

   // Exact product of the amplitude magnitude and the polynomial.
   mjt_mul #(
      .A_W (POLY_FRAC_W),
      .B_W (AMP_W)
   ) u_mul_amp (
      .clock    (clock),
      .stage_en (stage_adv[PROD_LAST:PROD_FIRST]),
      .a        (poly[POLY_FRAC_W-1:0]),
      .b        (side_ff[POLY_LAST].mag),
      .prod     (scaled)
   );

   // Floor toward minus infinity: a negative move rounds its magnitude up.
   assign scaled_hi   = scaled[POLY_FRAC_W +: AMP_W];
   assign scaled_frac = |scaled[POLY_FRAC_W-1:0];
   assign amp_neg     = side_ff[PROD_LAST].amp[AMP_W-1];
   assign curve       = amp_neg ? (AMP_W'(0) - (scaled_hi + AMP_W'(scaled_frac))) : scaled_hi;

   always_comb begin
      out_in.phase = side_ff[PROD_LAST].phase;
      case (side_ff[PROD_LAST].phase)
         PHASE_BEFORE: out_in.position = '0;
         PHASE_MOVING: out_in.position = curve;
         default:      out_in.position = side_ff[PROD_LAST].amp;
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (stage_adv[OUT_STAGE]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = valid_ff[OUT_STAGE];
   assign rsp_data  = out_ff;

   // An accepted request always occupies the entry stage next cycle.
   `ASSERT_NEXT(a_accept_fills_entry, clock, reset, req_valid && req_ready, valid_ff[0], "accepted request did not enter the pipeline")

   // A finished move reports the amplitude that traveled with it.
   `ASSERT_NEXT(a_done_gives_amp, clock, reset, stage_adv[OUT_STAGE] && valid_ff[PROD_LAST] && side_ff[PROD_LAST].phase == PHASE_DONE, rsp_data.position == $past(side_ff[PROD_LAST].amp), "finished move lost its amplitude")

   // A request before the start tick reports zero.
   `ASSERT_NEXT(a_before_gives_zero, clock, reset, stage_adv[OUT_STAGE] && valid_ff[PROD_LAST] && side_ff[PROD_LAST].phase == PHASE_BEFORE, rsp_data.position == '0, "position before start is not zero")

   // While moving, the scaled value never passes a non-negative amplitude;
   // a misaligned product and side data would break this.
   `ASSERT_CLK(a_moving_bounded, clock, reset, (valid_ff[PROD_LAST] && side_ff[PROD_LAST].phase == PHASE_MOVING && !amp_neg) |-> (scaled_hi <= side_ff[PROD_LAST].amp), "moving position exceeds amplitude")

endmodule

`default_nettype wire

@@ tb/sv/min_jerk_trajectory_point_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the minimum-jerk trajectory evaluator.
// Uses mjt_pkg and min_jerk_trajectory_point; predicts each response and checks it in order.

module min_jerk_trajectory_point_tb;
   import mjt_pkg::*;

   // Longest stretch of cycles with no accepted transfer before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 3000;
   // Pipeline depth, used for the quiet period at the end of the run.
   localparam int PIPE_LATENCY = 46;

   // Holds the register copy and the expected responses in request order.
   class trajectory_scoreboard;
      logic [TIME_W-1:0] start_tick;
      logic [TIME_W-1:0] end_tick;
      rsp_type expected_points[$];
      int failures;

      function new();
         start_tick = '0;
         end_tick = END_TICK_RESET;
         failures = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [TIME_W-1:0] value);
         case (idx)
            CSR_START_TICK: start_tick = value;
            CSR_END_TICK: end_tick = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      // Position along the quintic curve, floored exactly to the amplitude's LSB.
      function rsp_type position_at(req_type r);
         rsp_type p;
         logic [AMP_W-1:0] raw;
         logic [AMP_W-1:0] mag;
         logic [2*FRAC_W-1:0] ratio;
         logic [255:0] s_w;
         logic [255:0] inner;
         logic [255:0] prod;
         logic rem;
         raw = r.amplitude;
         if (r.time_tick < start_tick) begin
            p.position = '0;
            p.phase = PHASE_BEFORE;
         end else if (end_tick <= start_tick || r.time_tick >= end_tick) begin
            p.position = r.amplitude;
            p.phase = PHASE_DONE;
         end else begin
            // Normalized time as a truncated Q0.32 fraction.
            ratio = {r.time_tick - start_tick, {FRAC_W{1'b0}}} / (end_tick - start_tick);
            s_w = 256'(ratio[FRAC_W-1:0]);
            // 10 - 15 s + 6 s^2, scaled by 2^64.
            inner = (256'(POLY_C3) << (2 * FRAC_W)) + 256'(POLY_C5) * s_w * s_w
                    - ((256'(POLY_C4) * s_w) << FRAC_W);
            mag = raw[AMP_W-1] ? -raw : raw;
            prod = s_w * s_w * s_w * inner * 256'(mag);
            rem = |prod[POLY_FRAC_W-1:0];
            // Flooring a negative product rounds its magnitude up.
            p.position = raw[AMP_W-1] ? -(prod[POLY_FRAC_W +: AMP_W] + AMP_W'(rem))
                                      : prod[POLY_FRAC_W +: AMP_W];
            p.phase = PHASE_MOVING;
         end
         return p;
      endfunction

      function void note_request(req_type r);
         expected_points.push_back(position_at(r));
      endfunction

      function void check_response(rsp_type r);
         rsp_type want;
         if (expected_points.size() == 0) begin
            $error("response with nothing outstanding: position %0d, phase %0d",
                   r.position, r.phase);
            failures++;
            return;
         end
         want = expected_points.pop_front();
         if (r.position !== want.position) begin
            $error("position mismatch: expected %0d, actual %0d", want.position, r.position);
            failures++;
         end
         if (r.phase !== want.phase) begin
            $error("phase mismatch: expected %0d, actual %0d", want.phase, r.phase);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   trajectory_scoreboard sb = new();
   bit req_burst = 0;
   bit rsp_burst = 0;
   int rsp_hold_cycles = 0;
   int idle_cycles = 0;

   min_jerk_trajectory_point dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Record accepted requests and check accepted responses at the clock edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // Abandon the run when nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side: random stalls, bursts with no stall, and one long hold-off.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 5);
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
         if ($urandom_range(0, 99) < 2) rsp_burst = !rsp_burst;
      end
   end

   function automatic req_type make_req(logic [TIME_W-1:0] t, logic [AMP_W-1:0] a);
      req_type r;
      r.time_tick = t;
      r.amplitude = a;
      return r;
   endfunction

   // Mostly times inside the move window, with edges, early times and full-range noise.
   function automatic req_type random_request();
      logic [TIME_W-1:0] t;
      logic [AMP_W-1:0] a;
      logic [31:0] b;
      logic [TIME_W-1:0] span;
      int pick;
      span = sb.end_tick - sb.start_tick;
      pick = $urandom_range(0, 9);
      if (pick <= 5 && sb.end_tick > sb.start_tick) begin
         t = sb.start_tick + ($urandom % span);
      end else if (pick == 6) begin
         case ($urandom_range(0, 3))
            0: t = sb.start_tick - 1;
            1: t = sb.start_tick;
            2: t = sb.end_tick - 1;
            default: t = sb.end_tick;
         endcase
      end else if (pick == 7 && sb.start_tick != 0) begin
         t = $urandom % sb.start_tick;
      end else begin
         t = $urandom;
      end
      pick = $urandom_range(0, 9);
      b = $urandom;
      if (pick <= 4) begin
         a = b;
      end else if (pick <= 6) begin
         case ($urandom_range(0, 4))
            0: a = 32'h7FFF_FFFF;
            1: a = 32'h8000_0000;
            2: a = 32'hFFFF_FFFF;
            3: a = 32'h0000_0001;
            default: a = '0;
         endcase
      end else begin
         a = {{16{b[15]}}, b[15:0]};
      end
      return make_req(t, a);
   endfunction

   // One request: optional gap, then hold valid until it is taken.
   task automatic send_request(req_type r);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if ($urandom_range(0, 99) < 2) req_burst = !req_burst;
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) send_request(random_request());
   endtask

   // Stop sending and wait for every outstanding response.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx) << CSR_INDEX_LSB;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      // Leave the port idle before the next transfer.
      @(negedge clock);
   endtask

   task automatic configure(logic [TIME_W-1:0] start_value, logic [TIME_W-1:0] end_value);
      drain();
      csr_write(CSR_START_TICK, start_value);
      csr_write(CSR_END_TICK, end_value);
   endtask

   // Main sequence: directed requests, then random requests under several settings.
   initial begin
      logic [TIME_W-1:0] s;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: start of the move, tiny steps, midpoint, last tick and beyond.
      send_request(make_req(32'd0, 32'h7FFF_FFFF));
      send_request(make_req(32'd0, 32'h8000_0000));
      send_request(make_req(32'd1, 32'h8000_0000));
      send_request(make_req(32'd1, 32'h7FFF_FFFF));
      send_request(make_req(32'd400, 32'h7FFF_FFFF));
      send_request(make_req(32'd400, 32'h8000_0000));
      send_request(make_req(32'd400, 32'hFFFF_FFFF));
      send_request(make_req(32'd400, 32'h0000_0001));
      send_request(make_req(32'd399, 32'h0000_0000));
      send_request(make_req(32'd799, 32'h7FFF_FFFF));
      send_request(make_req(32'd799, 32'h8000_0000));
      send_request(make_req(32'd800, 32'h8000_0000));
      send_request(make_req(32'hFFFF_FFFF, 32'h7FFF_FFFF));
      send_request(make_req(32'hAAAA_AAAA, 32'h5555_5555));
      run_random(150);

      // End tick before the start tick: the move is finished as soon as it begins.
      configure(32'd1000, 32'd500);
      send_request(make_req(32'd999, 32'hAAAA_AAAA));
      send_request(make_req(32'd1000, 32'h8000_0000));
      send_request(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      run_random(60);

      // Equal start and end ticks.
      configure(32'd7, 32'd7);
      send_request(make_req(32'd6, 32'h0000_0001));
      send_request(make_req(32'd7, 32'hFFFF_FFFF));
      run_random(40);

      // Widest window, narrow window at the top of the range, one-tick window.
      configure(32'd0, 32'hFFFF_FFFF);
      run_random(200);
      configure(32'hFFFF_FF00, 32'hFFFF_FFFF);
      run_random(100);
      configure(32'd0, 32'd1);
      run_random(60);

      // Long receiver hold-off while requests keep coming, so the pipeline backs up.
      configure(32'd12345, 32'd13345);
      req_burst = 1;
      rsp_hold_cycles = 400;
      run_random(250);

      // Random windows, the last one possibly reversed.
      for (int k = 0; k < 4; k++) begin
         s = $urandom;
         configure(s, (k == 3) ? $urandom : s + $urandom_range(1, 100000));
         run_random(100);
      end

      drain();
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
